[rtl/core/bni_pkg.sv]
// Shared types and constants for the batch normalization block.
// Used by the parameter load unit and the top level; no dependencies.
`default_nettype none
package bni_pkg;
  localparam int Channels = 64;
  localparam int ChW = 6;
  localparam int EntryW = 64;  // mean 16, scale 32, shift 16

  localparam logic [1:0] RegEpsilon = 2'd0;
  localparam logic [1:0] RegUseGamma = 2'd1;
  localparam logic [1:0] RegUseBeta = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ChW-1:0]    addr;
    logic [EntryW-1:0] data;
  } tbl_wr_t;
endpackage
`default_nettype wire

[rtl/core/bni_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bni_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/core/bni_load.sv]
// Channel parameter load unit: square root and division, one bit per cycle,
// producing the Q16.16 scale. Depends on bni_pkg.
`default_nettype none
module bni_load import bni_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ChW-1:0]    channel_i,
  input  wire logic [15:0]       mean_i,
  input  wire logic [15:0]       variance_i,
  input  wire logic [15:0]       gamma_i,
  input  wire logic [15:0]       beta_i,
  input  wire logic [15:0]       epsilon_i,
  input  wire logic              use_gamma_i,
  input  wire logic              use_beta_i,
  output logic                   busy_o,
  output tbl_wr_t                wr_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSqrt = 2'd1;
  localparam logic [1:0] StDiv = 2'd2;
  localparam logic [1:0] StWrite = 2'd3;

  logic [1:0]     state_q, state_d;
  logic [5:0]     cnt_q, cnt_d;
  logic [57:0]    sh_q, sh_d;
  logic [30:0]    rem_q, rem_d;
  logic [28:0]    root_q, root_d;
  logic [48:0]    dvd_q, dvd_d;
  logic [28:0]    drem_q, drem_d;
  logic [15:0]    mag_q, mag_d;
  logic           neg_q, neg_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic [15:0]    mean_q, mean_d;
  logic [15:0]    beta_q, beta_d;

  logic [15:0] eps;
  logic [16:0] s;
  logic [15:0] g;
  logic [31:0] stmp, trial, sdiff;
  logic [29:0] dtmp;
  logic [31:0] scale;

  always_comb begin
    eps = (epsilon_i == 16'd0) ? 16'd1 : epsilon_i;
    s = {1'b0, variance_i} + {1'b0, eps};
    g = use_gamma_i ? gamma_i : 16'd256;
    stmp = {rem_q[29:0], sh_q[57:56]};
    trial = {1'b0, root_q, 2'b01};
    sdiff = stmp - trial;
    dtmp = {drem_q, dvd_q[48]};
    if (neg_q) begin
      scale = (dvd_q > 49'h0_8000_0000) ? 32'h8000_0000 : (~dvd_q[31:0] + 32'd1);
    end else begin
      scale = (dvd_q > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_q[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    sh_d = sh_q;
    rem_d = rem_q;
    root_d = root_q;
    dvd_d = dvd_q;
    drem_d = drem_q;
    mag_d = mag_q;
    neg_d = neg_q;
    ch_d = ch_q;
    mean_d = mean_q;
    beta_d = beta_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StSqrt;
          cnt_d = 6'd0;
          sh_d = {1'b0, s, 8'd0, 32'd0};
          rem_d = '0;
          root_d = '0;
          neg_d = g[15];
          mag_d = g[15] ? (~g + 16'd1) : g;
          ch_d = channel_i;
          mean_d = mean_i;
          beta_d = use_beta_i ? beta_i : 16'd0;
        end
      end
      StSqrt: begin
        sh_d = {sh_q[55:0], 2'b00};
        if (stmp >= trial) begin
          rem_d = sdiff[30:0];
          root_d = {root_q[27:0], 1'b1};
        end else begin
          rem_d = stmp[30:0];
          root_d = {root_q[27:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd28) begin
          state_d = StDiv;
          cnt_d = 6'd0;
          drem_d = '0;
          // Adding half the divisor rounds the quotient to nearest.
          dvd_d = {1'b0, mag_q, 32'd0} + {21'd0, root_d[28:1]};
        end
      end
      StDiv: begin
        if (dtmp >= {1'b0, root_q}) begin
          drem_d = 29'(dtmp - {1'b0, root_q});
          dvd_d = {dvd_q[47:0], 1'b1};
        end else begin
          drem_d = dtmp[28:0];
          dvd_d = {dvd_q[47:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd48) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    rem_q <= rem_d;
    root_q <= root_d;
    dvd_q <= dvd_d;
    drem_q <= drem_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    ch_q <= ch_d;
    mean_q <= mean_d;
    beta_q <= beta_d;
  end

  assign busy_o = (state_q != StIdle);
  assign wr_o.we = (state_q == StWrite) && ({1'b0, ch_q} < (ChW + 1)'(Channels));
  assign wr_o.addr = ch_q;
  assign wr_o.data = {mean_q, scale, beta_q};
endmodule
`default_nettype wire

[rtl/core/batch_norm_inference.sv]
// Top level of the batch normalization block: configuration registers,
// parameter table and the sample pipeline. Depends on bni_pkg, bni_ram, bni_load.
`default_nettype none
// A sample word is taken in any cycle in which busy_o is low, one per cycle, and
// its result appears on a one-cycle valid_o strobe after the four
// register stages: table read, mean subtract, scale multiply, and round plus
// shift with saturation. A load word keeps busy_o high while the square root
// and the rounded division run one bit per cycle in a shared iterative unit
// and while the table entry is written. The receiver cannot stall the output,
// so nothing here ever waits on it.
module batch_norm_inference import bni_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              opcode_i,
  input  wire logic [ChW-1:0]    channel_i,
  input  wire logic signed [15:0] sample_i,
  input  wire logic signed [15:0] mean_value_i,
  input  wire logic [15:0]       variance_value_i,
  input  wire logic signed [15:0] gamma_value_i,
  input  wire logic signed [15:0] beta_value_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  output logic                   valid_o,
  output logic signed [15:0]     result_o,
  output logic [ChW-1:0]         result_channel_o,
  output logic                   saturated_o
);
  logic [15:0] epsilon_q;
  logic        use_gamma_q, use_beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epsilon_q <= 16'd1;
      use_gamma_q <= 1'b1;
      use_beta_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegEpsilon: epsilon_q <= cfg_data_i;
        RegUseGamma: use_gamma_q <= cfg_data_i[0];
        RegUseBeta: use_beta_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic accept, load_go, samp_go;
  tbl_wr_t wr;
  logic [EntryW-1:0] rdata;

  assign accept = start_i && !busy_o;
  assign load_go = accept && (opcode_i == OpLoad);
  assign samp_go = accept && (opcode_i == OpSample);

  bni_load u_load (
    .clk_i, .rst_ni,
    .start_i    (load_go),
    .channel_i  (channel_i),
    .mean_i     (mean_value_i),
    .variance_i (variance_value_i),
    .gamma_i    (gamma_value_i),
    .beta_i     (beta_value_i),
    .epsilon_i  (epsilon_q),
    .use_gamma_i(use_gamma_q),
    .use_beta_i (use_beta_q),
    .busy_o     (busy_o),
    .wr_o       (wr)
  );

  bni_ram #(.WIDTH(EntryW), .DEPTH(Channels)) u_tbl (
    .clk_i,
    .we_i   (wr.we),
    .waddr_i(wr.addr),
    .wdata_i(wr.data),
    .raddr_i(channel_i),
    .rdata_o(rdata)
  );

  // Stage 1: table read in flight.
  logic v1_q, oor1_q;
  logic [ChW-1:0] ch1_q;
  logic signed [15:0] x1_q;
  // Stage 2: difference.
  logic v2_q, oor2_q;
  logic [ChW-1:0] ch2_q;
  logic signed [16:0] d2_q;
  logic signed [31:0] sc2_q;
  logic signed [15:0] b2_q;
  // Stage 3: product.
  logic v3_q, oor3_q;
  logic [ChW-1:0] ch3_q;
  logic signed [48:0] p3_q;
  logic signed [15:0] b3_q;

  logic signed [48:0] pr;
  logic signed [33:0] y;
  logic sat_hi, sat_lo;

  always_comb begin
    pr = p3_q + 49'sd32768;
    y = 34'(pr >>> 16) + 34'(b3_q);
    sat_hi = (y > 34'sd32767);
    sat_lo = (y < -34'sd32768);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q <= samp_go;
      v2_q <= v1_q;
      v3_q <= v2_q;
      valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    oor1_q <= ({1'b0, channel_i} >= (ChW + 1)'(Channels));
    ch1_q <= channel_i;
    x1_q <= sample_i;

    oor2_q <= oor1_q;
    ch2_q <= ch1_q;
    d2_q <= 17'(x1_q) - 17'($signed(rdata[63:48]));
    sc2_q <= $signed(rdata[47:16]);
    b2_q <= $signed(rdata[15:0]);

    oor3_q <= oor2_q;
    ch3_q <= ch2_q;
    p3_q <= 49'(d2_q) * 49'(sc2_q);
    b3_q <= b2_q;

    result_channel_o <= ch3_q;
    if (oor3_q) begin
      result_o <= '0;
      saturated_o <= 1'b0;
    end else if (sat_hi) begin
      result_o <= 16'sh7FFF;
      saturated_o <= 1'b1;
    end else if (sat_lo) begin
      result_o <= -16'sh8000;
      saturated_o <= 1'b1;
    end else begin
      result_o <= y[15:0];
      saturated_o <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[test/tb_batch_norm_inference.sv]
// Self-checking testbench for batch_norm_inference: loads channel parameters,
// streams samples and checks every result against a built-in predictor.
// Depends on bni_pkg and the batch_norm_inference RTL.
module tb_batch_norm_inference;
  import bni_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] value;
    logic [ChW-1:0]     chan;
    logic               clipped;
  } norm_word_t;

  class norm_scoreboard;
    logic signed [15:0] mean_tab[Channels];
    logic signed [31:0] scale_tab[Channels];
    logic signed [15:0] shift_tab[Channels];
    logic [15:0] eps = 16'd1;
    logic gamma_on = 1'b1;
    logic beta_on = 1'b1;
    norm_word_t pending[$];
    int errors = 0;

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Called for every word the block accepts.
    function void note_word(logic op, logic [ChW-1:0] ch, logic signed [15:0] smp,
                            logic signed [15:0] mean, logic [15:0] vari,
                            logic signed [15:0] gam, logic signed [15:0] bet);
      longint unsigned root, mag, quo, s;
      longint g, sc, d, y;
      norm_word_t w;
      if (op == OpLoad) begin
        s = longint'(vari) + ((eps == 0) ? 1 : longint'(eps));
        root = int_sqrt((s << 8) << 32);
        g = gamma_on ? longint'(gam) : 256;
        mag = (g < 0) ? -g : g;
        quo = ((mag << 32) + (root >> 1)) / root;
        if (g < 0) sc = (quo > (64'd1 << 31)) ? -(64'sd1 <<< 31) : -longint'(quo);
        else sc = (quo > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(quo);
        mean_tab[ch] = mean;
        scale_tab[ch] = sc[31:0];
        shift_tab[ch] = beta_on ? bet : 16'sd0;
      end else begin
        d = longint'(smp) - longint'(mean_tab[ch]);
        y = ((d * longint'(scale_tab[ch])) + 32768) >>> 16;
        y = y + longint'(shift_tab[ch]);
        w.clipped = 1'b0;
        if (y > 32767) begin
          y = 32767;
          w.clipped = 1'b1;
        end
        if (y < -32768) begin
          y = -32768;
          w.clipped = 1'b1;
        end
        w.value = y[15:0];
        w.chan = ch;
        pending.push_back(w);
      end
    endfunction

    function void check_word(logic signed [15:0] value, logic [ChW-1:0] chan,
                             logic clipped);
      norm_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected result word: result %0d channel %0d", value, chan);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (value !== w.value) begin
        $error("result: expected %0d, got %0d", w.value, value);
        errors++;
      end
      if (chan !== w.chan) begin
        $error("result_channel: expected %0d, got %0d", w.chan, chan);
        errors++;
      end
      if (clipped !== w.clipped) begin
        $error("saturated: expected %0d, got %0d", w.clipped, clipped);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic opcode_i = OpLoad;
  logic [ChW-1:0] channel_i = '0;
  logic signed [15:0] sample_i = '0;
  logic signed [15:0] mean_value_i = '0;
  logic [15:0] variance_value_i = '0;
  logic signed [15:0] gamma_value_i = '0;
  logic signed [15:0] beta_value_i = '0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = RegEpsilon;
  logic [15:0] cfg_data_i = '0;
  logic busy_o, valid_o, saturated_o;
  logic signed [15:0] result_o;
  logic [ChW-1:0] result_channel_o;

  norm_scoreboard sb = new();
  bit loaded[Channels];
  bit no_gaps = 0;

  batch_norm_inference uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_word(result_o, result_channel_o, saturated_o);
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Leaves start high after acceptance, bar random gaps, for back-to-back words.
  task automatic send_word(logic op, logic [ChW-1:0] ch, logic signed [15:0] smp,
                           logic signed [15:0] mean, logic [15:0] vari,
                           logic signed [15:0] gam, logic signed [15:0] bet);
    start_i <= 1'b1;
    opcode_i <= op;
    channel_i <= ch;
    sample_i <= smp;
    mean_value_i <= mean;
    variance_value_i <= vari;
    gamma_value_i <= gam;
    beta_value_i <= bet;
    do @(posedge clk_i); while (busy_o);
    sb.note_word(op, ch, smp, mean, vari, gam, bet);
    if (op == OpLoad) loaded[ch] = 1;
    if (!no_gaps && $urandom_range(99) < 19) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic load_channel(logic [ChW-1:0] ch);
    send_word(OpLoad, ch, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic sample_channel(logic [ChW-1:0] ch, logic signed [15:0] smp);
    send_word(OpSample, ch, smp, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  // Waits until every result is in and no load is still computing.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_config(logic [15:0] eps, logic gam_on, logic bet_on);
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegEpsilon;
    cfg_data_i <= eps;
    @(posedge clk_i);
    cfg_index_i <= RegUseGamma;
    cfg_data_i <= {15'd0, gam_on};
    @(posedge clk_i);
    cfg_index_i <= RegUseBeta;
    cfg_data_i <= {15'd0, bet_on};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.eps = eps;
    sb.gamma_on = gam_on;
    sb.beta_on = bet_on;
  endtask

  task automatic random_phase(int count);
    logic [ChW-1:0] ch;
    logic signed [15:0] smp;
    for (int i = 0; i < count; i++) begin
      ch = ChW'($urandom_range(Channels - 1));
      if ($urandom_range(99) < 12 || !loaded[ch]) begin
        load_channel(ch);
      end else begin
        // Half the samples lie near the channel mean, so results are not all clipped.
        if ($urandom_range(1)) begin
          smp = 16'(sb.mean_tab[ch] + $signed(16'($urandom_range(0, 1023))) - 512);
        end else begin
          smp = 16'($urandom);
        end
        sample_channel(ch, smp);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_config(16'd1, 1'b1, 1'b1);

    // Directed: field extremes, zero epsilon, both gamma and beta choices.
    send_word(OpLoad, 0, 0, 16'sh7FFF, 16'd0, 16'sh7FFF, 16'sh7FFF);
    send_word(OpLoad, 63, 0, -16'sh8000, 16'hFFFF, -16'sh8000, -16'sh8000);
    send_word(OpLoad, 1, 0, 16'sd0, 16'd256, 16'sd0, 16'sd0);
    send_word(OpLoad, 2, 0, 16'sd128, 16'd1, -16'sh8000, 16'sh7FFF);
    sample_channel(0, -16'sh8000);
    sample_channel(0, 16'sh7FFF);
    sample_channel(63, 16'sh7FFF);
    sample_channel(63, -16'sh8000);
    sample_channel(1, 16'sh1234);
    sample_channel(2, 16'sh7FFF);
    sample_channel(2, -16'sh8000);
    drain();
    write_config(16'd0, 1'b0, 1'b0);
    send_word(OpLoad, 3, 0, 16'sd0, 16'd0, 16'sd100, 16'sd100);
    send_word(OpLoad, 62, 0, 16'sd256, 16'd65535, 16'sd5, -16'sd5);
    sample_channel(3, 16'sh0100);
    sample_channel(3, -16'sh8000);
    sample_channel(62, 16'sh7FFF);
    // Channel 0 keeps the gamma and beta stored under the earlier setting.
    sample_channel(0, 16'sh0000);
    drain();

    write_config(16'd65535, 1'b1, 1'b0);
    random_phase(150);
    drain();
    write_config(16'd1, 1'b0, 1'b1);
    no_gaps = 1;
    random_phase(150);
    no_gaps = 0;
    drain();
    write_config(16'($urandom_range(1, 65535)), 1'b1, 1'b1);
    random_phase(150);
    drain();
    write_config(16'($urandom_range(1, 255)), 1'($urandom), 1'($urandom));
    random_phase(130);
    drain();
    write_config(16'd1, 1'b1, 1'b1);
    random_phase(150);
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
